// ===== hdl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Types, constants and helpers of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned MaxResults = 16;

  localparam int unsigned IdxW  = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned RelW  = $clog2(MaxResults + 1);
  localparam int unsigned DlyW  = 32;
  localparam int unsigned TaskW = 8;

  localparam logic [DlyW-1:0] DefaultDelayReset = DlyW'(1966);

  typedef enum logic [1:0] {
    OP_SCHED     = 2'd0,
    OP_SCHED_DEF = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_FULL      = 2'd1,
    KIND_RELEASED  = 2'd2,
    KIND_NONE_DUE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_INSERT_HEAD,
    ST_RELEASE
  } state_e;

  typedef struct packed {
    logic [TimeBits-1:0] wake;
    logic [TaskW-1:0]    task_id;
  } entry_t;

  // Saturating add of a Q16.16 delay onto a Q(TimeBits-16).16 time.
  function automatic logic [TimeBits-1:0] time_add(input logic [TimeBits-1:0] base,
                                                    input logic [DlyW-1:0] add);
    logic [TimeBits:0] sum;
    sum = {1'b0, base} + (TimeBits + 1)'(add);
    if (sum[TimeBits]) begin
      return '1;
    end
    return sum[TimeBits-1:0];
  endfunction

  // Physical slot of a queue position, counted from the head, wrapping round.
  function automatic logic [IdxW-1:0] slot_addr(input logic [IdxW-1:0] head,
                                                 input logic [IdxW-1:0] offs);
    logic [IdxW:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (sum >= (IdxW + 1)'(QueueDepth)) begin
      sum = sum - (IdxW + 1)'(QueueDepth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

// ===== hdl/deadline_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// Deadline-ordered task queue held in a circular buffer in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation_i, task_id_i, delay_i and elapsed_i with
//   start_i; the command is taken at a clock edge where busy_o is low.
//   Results come out one per cycle, each marked by result_valid_o for a single
//   cycle; last_o flags the final result of a command.
//   Schedule: the task is placed after every entry that wakes no later. The
//   insertion walks the queue from the tail, one entry per cycle through the
//   RAM read port; an empty or full queue is answered straight from idle,
//   and a walk registers its result as the new task is written.
//   Tick: advances the time, then pops up to MaxResults due tasks from the
//   head, one per cycle (one RAM read each); each released task is reported
//   in the cycle after the next head is judged. default_delay is written
//   by default_delay_we_i; the user must do it only while idle, unenforced.
//   Reset clears time, count and head pointer; RAM contents need no clearing.
//   The receiver cannot stall: every result must be taken as it appears.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 operation_i,
  input  logic [dtq_pkg::TaskW-1:0]  task_id_i,
  input  logic [dtq_pkg::DlyW-1:0]   delay_i,
  input  logic [dtq_pkg::DlyW-1:0]   elapsed_i,
  input  logic                       default_delay_we_i,
  input  logic [dtq_pkg::DlyW-1:0]   default_delay_i,
  output logic                       result_valid_o,
  output logic [1:0]                 kind_o,
  output logic [dtq_pkg::TaskW-1:0]  released_id_o,
  output logic                       last_o,
  output logic                       queue_empty_o
);
  import dtq_pkg::*;

  state_e              state_q, state_d;
  logic [TimeBits-1:0] now_q, now_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  entry_t              new_q, new_d;
  logic [RelW-1:0]     rel_cnt_q, rel_cnt_d;
  logic                pend_q, pend_d;
  logic [TaskW-1:0]    pend_id_q, pend_id_d;
  logic [DlyW-1:0]     dflt_q;

  logic                res_valid_q, res_valid_d;
  kind_e               kind_q, kind_d;
  logic [TaskW-1:0]    res_id_q, res_id_d;
  logic                last_q, last_d;
  logic                empty_q, empty_d;

  entry_t              mem_q [QueueDepth];
  entry_t              rd_q;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [IdxW-1:0]     mem_raddr;
  entry_t              mem_wdata;

  logic [CntW-1:0]     count_m1;
  logic [DlyW-1:0]     sched_delay;
  logic                due;

  assign count_m1 = count_q - CntW'(1);
  assign due      = (count_q != '0) && (rel_cnt_q != RelW'(MaxResults)) &&
                    (rd_q.wake <= now_q);

  // Queue storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= DefaultDelayReset;
    end else if (default_delay_we_i) begin
      dflt_q <= default_delay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      count_q     <= '0;
      head_q      <= '0;
      rel_cnt_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      count_q     <= count_d;
      head_q      <= head_d;
      rel_cnt_q   <= rel_cnt_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    new_q     <= new_d;
    pend_id_q <= pend_id_d;
    kind_q    <= kind_d;
    res_id_q  <= res_id_d;
    last_q    <= last_d;
    empty_q   <= empty_d;
  end

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    count_d     = count_q;
    head_d      = head_q;
    pos_d       = pos_q;
    new_d       = new_q;
    rel_cnt_d   = rel_cnt_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    res_id_d    = res_id_q;
    last_d      = last_q;
    empty_d     = empty_q;
    mem_we      = 1'b0;
    mem_waddr   = head_q;
    mem_wdata   = new_q;
    mem_raddr   = head_q;
    sched_delay = (op_e'(operation_i) == OP_SCHED) ? delay_i : dflt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (op_e'(operation_i))
            OP_SCHED, OP_SCHED_DEF: begin
              new_d.wake    = time_add(now_q, sched_delay);
              new_d.task_id = task_id_i;
              if (count_q == CntW'(QueueDepth)) begin
                res_valid_d = 1'b1;
                kind_d      = KIND_FULL;
                res_id_d    = task_id_i;
                last_d      = 1'b1;
                empty_d     = 1'b0;
              end else if (count_q == '0) begin
                mem_we      = 1'b1;
                mem_waddr   = head_q;
                mem_wdata   = new_d;
                count_d     = CntW'(1);
                res_valid_d = 1'b1;
                kind_d      = KIND_SCHEDULED;
                res_id_d    = task_id_i;
                last_d      = 1'b1;
                empty_d     = 1'b0;
              end else begin
                // Start the walk at the tail entry.
                pos_d     = count_m1[IdxW-1:0];
                mem_raddr = slot_addr(head_q, count_m1[IdxW-1:0]);
                state_d   = ST_INSERT;
              end
            end
            OP_TICK: begin
              now_d     = time_add(now_q, elapsed_i);
              mem_raddr = head_q;
              rel_cnt_d = '0;
              pend_d    = 1'b0;
              state_d   = ST_RELEASE;
            end
            default: begin
            end
          endcase
        end
      end

      ST_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = slot_addr(head_q, pos_q + IdxW'(1));
        if (rd_q.wake > new_q.wake) begin
          // Move this entry one place back and keep walking.
          mem_wdata = rd_q;
          if (pos_q == '0) begin
            state_d = ST_INSERT_HEAD;
          end else begin
            pos_d     = pos_q - IdxW'(1);
            mem_raddr = slot_addr(head_q, pos_q - IdxW'(1));
          end
        end else begin
          mem_wdata   = new_q;
          count_d     = count_q + CntW'(1);
          res_valid_d = 1'b1;
          kind_d      = KIND_SCHEDULED;
          res_id_d    = new_q.task_id;
          last_d      = 1'b1;
          empty_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      ST_INSERT_HEAD: begin
        mem_we      = 1'b1;
        mem_waddr   = head_q;
        mem_wdata   = new_q;
        count_d     = count_q + CntW'(1);
        res_valid_d = 1'b1;
        kind_d      = KIND_SCHEDULED;
        res_id_d    = new_q.task_id;
        last_d      = 1'b1;
        empty_d     = 1'b0;
        state_d     = ST_IDLE;
      end

      ST_RELEASE: begin
        // A popped task is held back in pend until the next head is judged, so that last can be decided.
        if (due) begin
          if (pend_q) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_RELEASED;
            res_id_d    = pend_id_q;
            last_d      = 1'b0;
            empty_d     = (count_q == '0);
          end
          pend_d    = 1'b1;
          pend_id_d = rd_q.task_id;
          head_d    = slot_addr(head_q, IdxW'(1));
          mem_raddr = slot_addr(head_q, IdxW'(1));
          count_d   = count_q - CntW'(1);
          rel_cnt_d = rel_cnt_q + RelW'(1);
        end else begin
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          empty_d     = (count_q == '0);
          if (pend_q) begin
            kind_d   = KIND_RELEASED;
            res_id_d = pend_id_q;
          end else begin
            kind_d   = KIND_NONE_DUE;
            res_id_d = '0;
          end
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign released_id_o  = res_id_q;
  assign last_o         = last_q;
  assign queue_empty_o  = empty_q;

endmodule
